[hw/rtl/dles_pkg.sv]
package dles_pkg;

  // strip size and fixed arithmetic widths
  localparam int MAX_LEDS  = 64;
  localparam int DIV_NUM_W = 25;
  localparam int DIV_DEN_W = 17;
  localparam int POS_W     = 12;

  typedef enum logic [2:0] {
    REG_NUM_LEDS,
    REG_MIN_DIST,
    REG_MAX_DIST,
    REG_LIGHT_SPAN,
    REG_CENTER_SHIFT,
    REG_LIGHT_MODE,
    REG_BASE_COLOR,
    REG_TRAIL_SETUP
  } reg_idx_e;

  typedef enum logic [2:0] {
    MODE_STANDARD = 3'd0,
    MODE_RAINBOW  = 3'd1,
    MODE_WAVE     = 3'd2,
    MODE_BREATH   = 3'd3,
    MODE_SOLID    = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    DIR_NONE   = 2'd0,
    DIR_AWAY   = 2'd1,
    DIR_CLOSER = 2'd2
  } dir_e;

  typedef enum logic [2:0] {
    JOB_MAP,
    JOB_START_R,
    JOB_START_G,
    JOB_START_B,
    JOB_STEP_R,
    JOB_STEP_G,
    JOB_STEP_B
  } div_job_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP_GO,
    ST_MAP_WAIT,
    ST_TRAIL_GO,
    ST_TRAIL_WAIT,
    ST_PIXELS
  } state_e;

  typedef struct packed {
    logic     load_frame;
    logic     div_start;
    div_job_e div_job;
    logic     div_capture;
    logic     pix_issue;
  } dles_cmd_t;

  typedef struct packed {
    logic div_done;
    logic trail_on;
    logic pix_last;
    logic out_free;
  } dles_status_t;

  typedef logic [8:0] wtab256_t [256];
  typedef logic [8:0] wtab64_t [64];

  // sine weight 0..256 for a 16-bit phase, evaluated at elaboration only
  function automatic logic [8:0] sine_weight(input logic [15:0] p);
    logic [63:0] x;
    logic [63:0] u;
    logic [63:0] den;
    logic [63:0] num;
    logic [8:0]  m;
    x   = {49'd0, p[14:0]};
    u   = x * (64'd32768 - x);
    den = 64'd5368709120 - (u << 2);
    num = (u << 11) + (den >> 1);
    m   = '0;
    for (int k = 1; k <= 128; k++) begin
      if (64'(k) * den <= num) m = 9'(k);
    end
    return p[15] ? (9'd128 - m) : (9'd128 + m);
  endfunction

  function automatic wtab256_t build_wave_lo();
    wtab256_t    t;
    logic [31:0] v;
    for (int j = 0; j < 256; j++) begin
      v    = 32'(j * 1043);
      t[j] = sine_weight(v[15:0]);
    end
    return t;
  endfunction

  function automatic wtab64_t build_wave_hi();
    wtab64_t     t;
    logic [31:0] v;
    for (int j = 0; j < 64; j++) begin
      v    = 32'((j + 256) * 1043);
      t[j] = sine_weight(v[15:0]);
    end
    return t;
  endfunction

  function automatic wtab256_t build_breath();
    wtab256_t    t;
    logic [31:0] v;
    for (int j = 0; j < 256; j++) begin
      v    = 32'((j * 1043) >> 1);
      t[j] = sine_weight(v[15:0]);
    end
    return t;
  endfunction

  // wave weights for pixel+step below 256 and from 256 up, breathing per step
  localparam wtab256_t WAVE_LO_W = build_wave_lo();
  localparam wtab64_t  WAVE_HI_W = build_wave_hi();
  localparam wtab256_t BREATH_W  = build_breath();

endpackage

[hw/rtl/dles_div.sv]
module dles_div import dles_pkg::*; #(
  parameter int NumW = DIV_NUM_W,
  parameter int DenW = DIV_DEN_W
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o,
  output logic [DenW-1:0] rem_o
);

  localparam int CntW = $clog2(NumW + 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [DenW-1:0] den_q;
  logic [DenW:0]   rem_sh;
  logic [DenW:0]   rem_sub;

  // one restoring step per cycle
  always_comb begin
    rem_sh  = {rem_q, quo_q[NumW-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    if (rem_sh >= {1'b0, den_q}) begin
      rem_d = rem_sub[DenW-1:0];
      quo_d = {quo_q[NumW-2:0], 1'b1};
    end else begin
      rem_d = rem_sh[DenW-1:0];
      quo_d = {quo_q[NumW-2:0], 1'b0};
    end
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

[hw/rtl/dles_ctrl.sv]
module dles_ctrl import dles_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  dles_status_t status_i,
  output dles_cmd_t    cmd_o
);

  state_e   state_q, state_d;
  div_job_e job_q, job_d;

  // state and job registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      job_q   <= JOB_MAP;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    job_d         = job_q;
    cmd_o         = '0;
    cmd_o.div_job = job_q;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_frame = 1'b1;
          job_d            = JOB_MAP;
          state_d          = ST_MAP_GO;
        end
      end
      ST_MAP_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_MAP_WAIT;
      end
      ST_MAP_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.div_capture = 1'b1;
          if (status_i.trail_on) begin
            job_d   = JOB_START_R;
            state_d = ST_TRAIL_GO;
          end else begin
            state_d = ST_PIXELS;
          end
        end
      end
      ST_TRAIL_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_TRAIL_WAIT;
      end
      ST_TRAIL_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.div_capture = 1'b1;
          if (job_q == JOB_STEP_B) begin
            state_d = ST_PIXELS;
          end else begin
            job_d   = div_job_e'(job_q + 3'd1);
            state_d = ST_TRAIL_GO;
          end
        end
      end
      ST_PIXELS: begin
        if (status_i.out_free) begin
          cmd_o.pix_issue = 1'b1;
          if (status_i.pix_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[hw/rtl/dles_dp.sv]
module dles_dp import dles_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [23:0]  cfg_wdata_i,
  input  logic [15:0]  distance_i,
  input  dles_cmd_t    cmd_i,
  output dles_status_t status_o,
  input  logic         out_ready_i,
  output logic         out_valid_o,
  output logic [5:0]   pixel_index_o,
  output logic [7:0]   red_o,
  output logic [7:0]   green_o,
  output logic [7:0]   blue_o,
  output logic         last_pixel_o
);

  // configuration registers
  logic [6:0]        num_leds_q;
  logic [15:0]       min_dist_q, max_dist_q;
  logic [6:0]        span_q;
  logic signed [7:0] shift_q;
  logic [2:0]        mode_q;
  logic [23:0]       color_q;
  logic [9:0]        trail_q;

  // frame state
  logic [15:0]             dist_q, last_pos_q;
  dir_e                    dir_q;
  logic [7:0]              step_q;
  logic signed [POS_W-1:0] s_q;
  logic [5:0]              pix_q;
  logic [2:0][7:0]         acc_quo_q, stp_quo_q;
  logic [2:0][10:0]        acc_rem_q, stp_rem_q;

  // output register
  logic       out_valid_q;
  logic [5:0] out_idx_q;
  logic [7:0] out_r_q, out_g_q, out_b_q;
  logic       out_last_q;

  logic [6:0]                n_eff;
  logic signed [7:0]         hi;
  logic signed [16:0]        dnum, dden, move;
  logic signed [24:0]        prod;
  logic [DIV_NUM_W-1:0]      prod_mag;
  logic [DIV_DEN_W-1:0]      den_mag;
  logic                      map_neg;
  logic signed [DIV_NUM_W:0] sq;
  logic signed [7:0]         s_clamp;
  logic signed [POS_W-1:0]   s_next;
  logic [7:0]                tl;
  logic [10:0]               five_t;
  logic signed [POS_W-1:0]   t_ext, span_ext, lo, top, ref_pos, i0, dd, dmag, ix;
  logic [7:0]                k0;
  logic [2:0][7:0]           col;
  logic [1:0]                job_ch;
  logic [7:0]                c_sel;
  logic [15:0]               ck;
  logic [DIV_NUM_W-1:0]      div_num;
  logic [DIV_DEN_W-1:0]      div_den;
  logic                      div_done;
  logic [DIV_NUM_W-1:0]      div_quo;
  logic [DIV_DEN_W-1:0]      div_rem;
  logic                      trail_act, std_mode, in_win, in_trail, pix_last;
  logic [8:0]                j;
  logic [8:0]                w_sel;
  logic [7:0]                wpos, wr, wg, wb;
  logic [9:0]                w3;
  logic [2:0][7:0]           px;
  logic [2:0][7:0]           acc_quo_d;
  logic [2:0][10:0]          acc_rem_d;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_leds_q <= 7'd64;
      min_dist_q <= 16'd30;
      max_dist_q <= 16'd300;
      span_q     <= 7'd3;
      shift_q    <= '0;
      mode_q     <= MODE_STANDARD;
      color_q    <= 24'hFFFFFF;
      trail_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_NUM_LEDS:     num_leds_q <= cfg_wdata_i[6:0];
        REG_MIN_DIST:     min_dist_q <= cfg_wdata_i[15:0];
        REG_MAX_DIST:     max_dist_q <= cfg_wdata_i[15:0];
        REG_LIGHT_SPAN:   span_q     <= cfg_wdata_i[6:0];
        REG_CENTER_SHIFT: shift_q    <= cfg_wdata_i[7:0];
        REG_LIGHT_MODE:   mode_q     <= cfg_wdata_i[2:0];
        REG_BASE_COLOR:   color_q    <= cfg_wdata_i;
        REG_TRAIL_SETUP:  trail_q    <= cfg_wdata_i[9:0];
      endcase
    end
  end

  // led count saturation and mapping operands
  always_comb begin
    if (num_leds_q == '0) n_eff = 7'd1;
    else if (num_leds_q > 7'(MAX_LEDS)) n_eff = 7'(MAX_LEDS);
    else n_eff = num_leds_q;
  end

  assign hi       = $signed({1'b0, n_eff}) - $signed({1'b0, span_q});
  assign dnum     = $signed({1'b0, dist_q}) - $signed({1'b0, min_dist_q});
  assign dden     = $signed({1'b0, max_dist_q}) - $signed({1'b0, min_dist_q});
  assign prod     = dnum * hi;
  assign prod_mag = prod[24] ? DIV_NUM_W'(-prod) : DIV_NUM_W'(prod);
  assign den_mag  = dden[16] ? DIV_DEN_W'(-dden) : DIV_DEN_W'(dden);
  assign map_neg  = prod[24] ^ dden[16];
  assign move     = $signed({1'b0, distance_i}) - $signed({1'b0, last_pos_q});

  // signed quotient, clamp and shift
  always_comb begin
    sq = $signed({1'b0, div_quo});
    if (map_neg) sq = -sq;
    if (max_dist_q == min_dist_q) sq = '0;
    if (sq < 0) s_clamp = '0;
    else if (sq > hi) s_clamp = hi;
    else s_clamp = sq[7:0];
    s_next = {{(POS_W-8){s_clamp[7]}}, s_clamp} + {{(POS_W-8){shift_q[7]}}, shift_q};
  end

  // trail geometry
  assign tl        = trail_q[7:0];
  assign five_t    = {1'b0, tl, 2'b00} + {3'b000, tl};
  assign t_ext     = $signed({{(POS_W-8){1'b0}}, tl});
  assign span_ext  = $signed({{(POS_W-7){1'b0}}, span_q});
  assign trail_act = trail_q[8] && (tl != '0) && (dir_q != DIR_NONE);
  assign std_mode  = !(mode_q == MODE_RAINBOW || mode_q == MODE_WAVE ||
                       mode_q == MODE_BREATH || mode_q == MODE_SOLID);

  always_comb begin
    if (dir_q == DIR_AWAY) begin
      lo      = s_q - t_ext;
      top     = s_q;
      ref_pos = s_q;
    end else begin
      lo      = s_q + span_ext;
      top     = s_q + span_ext + t_ext;
      ref_pos = s_q + span_ext;
    end
    i0   = lo[POS_W-1] ? '0 : lo;
    dd   = i0 - ref_pos;
    dmag = dd[POS_W-1] ? -dd : dd;
    k0   = (dmag > t_ext) ? 8'd0 : 8'(t_ext - dmag);
  end

  // divider operand selection
  assign col[0] = color_q[23:16];
  assign col[1] = color_q[15:8];
  assign col[2] = color_q[7:0];

  always_comb begin
    unique case (cmd_i.div_job)
      JOB_START_R, JOB_STEP_R: job_ch = 2'd0;
      JOB_START_G, JOB_STEP_G: job_ch = 2'd1;
      default:                 job_ch = 2'd2;
    endcase
    c_sel = col[job_ch];
    ck    = c_sel * k0;
    unique case (cmd_i.div_job)
      JOB_MAP: begin
        div_num = prod_mag;
        div_den = den_mag;
      end
      JOB_START_R, JOB_START_G, JOB_START_B: begin
        div_num = DIV_NUM_W'({ck, 2'b00});
        div_den = DIV_DEN_W'(five_t);
      end
      default: begin
        div_num = DIV_NUM_W'({c_sel, 2'b00});
        div_den = DIV_DEN_W'(five_t);
      end
    endcase
  end

  dles_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // pixel position tests
  assign ix       = $signed({{(POS_W-6){1'b0}}, pix_q});
  assign in_win   = (ix >= s_q) && (ix < s_q + span_ext);
  assign in_trail = trail_act && (ix >= lo) && (ix < top);
  assign pix_last = ({1'b0, pix_q} == n_eff - 7'd1);
  assign j        = {3'b000, pix_q} + {1'b0, step_q};

  // color wheel
  always_comb begin
    wpos = 8'd255 - j[7:0];
    w3   = '0;
    if (wpos < 8'd85) begin
      w3 = {wpos, 1'b0} + {2'b00, wpos};
      wr = 8'd255 - w3[7:0];
      wg = '0;
      wb = w3[7:0];
    end else if (wpos < 8'd170) begin
      w3 = {(wpos - 8'd85), 1'b0} + {2'b00, (wpos - 8'd85)};
      wr = '0;
      wg = w3[7:0];
      wb = 8'd255 - w3[7:0];
    end else begin
      w3 = {(wpos - 8'd170), 1'b0} + {2'b00, (wpos - 8'd170)};
      wr = w3[7:0];
      wg = 8'd255 - w3[7:0];
      wb = '0;
    end
  end

  // sine weight lookup
  always_comb begin
    if (mode_q == MODE_WAVE) w_sel = j[8] ? WAVE_HI_W[j[5:0]] : WAVE_LO_W[j[7:0]];
    else w_sel = BREATH_W[step_q];
  end

  // pixel color per mode
  always_comb begin
    logic [16:0] scaled;
    logic [15:0] bgp;
    for (int ch = 0; ch < 3; ch++) begin
      scaled = col[ch] * w_sel;
      bgp    = col[ch] * 8'd205;
      unique case (mode_q)
        MODE_RAINBOW: px[ch] = '0;
        MODE_WAVE, MODE_BREATH: px[ch] = scaled[15:8];
        MODE_SOLID: px[ch] = col[ch];
        default: begin
          px[ch] = trail_q[9] ? {4'b0000, bgp[15:12]} : 8'd0;
          if (in_win) px[ch] = col[ch];
          if (in_trail) px[ch] = acc_quo_q[ch];
        end
      endcase
    end
    if (mode_q == MODE_RAINBOW) px = {wb, wg, wr};
  end

  // trail accumulator step, up when moving away and down when closer
  always_comb begin
    logic [11:0] rsum;
    for (int ch = 0; ch < 3; ch++) begin
      if (dir_q == DIR_AWAY) begin
        rsum = {1'b0, acc_rem_q[ch]} + {1'b0, stp_rem_q[ch]};
        if (rsum >= {1'b0, five_t}) begin
          acc_rem_d[ch] = 11'(rsum - {1'b0, five_t});
          acc_quo_d[ch] = acc_quo_q[ch] + stp_quo_q[ch] + 8'd1;
        end else begin
          acc_rem_d[ch] = rsum[10:0];
          acc_quo_d[ch] = acc_quo_q[ch] + stp_quo_q[ch];
        end
      end else begin
        rsum = {1'b0, acc_rem_q[ch]} - {1'b0, stp_rem_q[ch]};
        if (rsum[11]) begin
          acc_rem_d[ch] = 11'(rsum + {1'b0, five_t});
          acc_quo_d[ch] = acc_quo_q[ch] - stp_quo_q[ch] - 8'd1;
        end else begin
          acc_rem_d[ch] = rsum[10:0];
          acc_quo_d[ch] = acc_quo_q[ch] - stp_quo_q[ch];
        end
      end
    end
  end

  // motion tracking, animation step and pixel counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pos_q <= '0;
      dir_q      <= DIR_NONE;
      step_q     <= '0;
      pix_q      <= '0;
    end else if (cmd_i.load_frame) begin
      pix_q <= '0;
      if (move > 17'sd5 || move < -17'sd5) begin
        last_pos_q <= distance_i;
        dir_q      <= move[16] ? DIR_CLOSER : DIR_AWAY;
      end
    end else if (cmd_i.pix_issue) begin
      pix_q <= pix_q + 6'd1;
      if (pix_last) step_q <= step_q + 8'd1;
    end
  end

  // frame payload: reading, window start, trail accumulators
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_frame) dist_q <= distance_i;
    if (cmd_i.div_capture) begin
      unique case (cmd_i.div_job)
        JOB_MAP: s_q <= s_next;
        JOB_START_R, JOB_START_G, JOB_START_B: begin
          acc_quo_q[job_ch] <= div_quo[7:0];
          acc_rem_q[job_ch] <= div_rem[10:0];
        end
        default: begin
          stp_quo_q[job_ch] <= div_quo[7:0];
          stp_rem_q[job_ch] <= div_rem[10:0];
        end
      endcase
    end else if (cmd_i.pix_issue && in_trail) begin
      acc_quo_q <= acc_quo_d;
      acc_rem_q <= acc_rem_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.pix_issue) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_issue) begin
      out_idx_q  <= pix_q;
      out_r_q    <= px[0];
      out_g_q    <= px[1];
      out_b_q    <= px[2];
      out_last_q <= pix_last;
    end
  end

  assign status_o.div_done = div_done;
  assign status_o.trail_on = trail_act && std_mode;
  assign status_o.pix_last = pix_last;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign pixel_index_o = out_idx_q;
  assign red_o         = out_r_q;
  assign green_o       = out_g_q;
  assign blue_o        = out_b_q;
  assign last_pixel_o  = out_last_q;

endmodule

[hw/rtl/distance_led_strip_effects_top.sv]
// Distance driven LED strip effects. Each accepted distance reading produces one frame:
// one RGB request per driven LED, pixel 0 first, last_pixel set on the final one. For a
// frame, one 25-iteration run of the shared bit-serial divider maps the distance to the
// window start, then one pixel leaves per cycle while the output side takes them. In
// standard mode with an active trail, six more divider runs set up the trail fade for
// the three channels first. The next reading is taken once the last pixel of a frame
// sits in the output register. Configuration registers are written through cfg_we_i,
// cfg_index_i, cfg_wdata_i and must only change while no frame is in progress.
module distance_led_strip_effects_top import dles_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] distance_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  pixel_index_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic        last_pixel_o
);

  dles_cmd_t    cmd;
  dles_status_t status;

  // frame sequencer
  dles_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // mapping, effects and output register
  dles_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .distance_i    (distance_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .pixel_index_o (pixel_index_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule

[hw/rtl/dles_checker.sv]
module dles_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic [2:0]  cfg_index_i,
  input logic [23:0] cfg_wdata_i,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [15:0] distance_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [5:0]  pixel_index_o,
  input logic [7:0]  red_o,
  input logic [7:0]  green_o,
  input logic [7:0]  blue_o,
  input logic        last_pixel_o
);

  logic [5:0] exp_q;

  // expected index of the next pixel request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) exp_q <= '0;
    else if (out_valid_o && out_ready_i) exp_q <= last_pixel_o ? 6'd0 : pixel_index_o + 6'd1;
  end

  // pixels of a frame come in order from zero
  a_pixel_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pixel_index_o == exp_q)
    else $error("pixel index out of sequence");

  // a stalled pixel request holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
    $stable({pixel_index_o, red_o, green_o, blue_o, last_pixel_o}))
    else $error("output request changed while stalled");

  // a new reading is taken only between frames
  a_accept_between: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> !out_valid_o || last_pixel_o)
    else $error("reading accepted in the middle of a frame");

  // the next frame cannot follow its predecessor without a mapping gap
  a_frame_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_pixel_o |=> !out_valid_o)
    else $error("pixel request right after end of frame");

endmodule

bind distance_led_strip_effects_top dles_checker u_dles_checker (.*);
